// File: design/ghash_pkg.sv
// ghash_pkg: shared constants, command and register codes, and GF(2^128) helpers
// used by the GHASH accumulator and its key table logic.
// Depends on nothing.
package ghash_pkg;

  localparam int BLOCK_W        = 128;
  localparam int HALF_W         = 64;
  localparam int VBYTES_W       = 5;
  localparam int CMD_W          = 2;
  localparam int S_TDATA_W      = 136;
  localparam int M_TDATA_W      = 128;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 64;
  localparam int DIGIT_BITS_DEF = 4;
  localparam int MAX_DIGIT_BITS = 8;

  localparam logic [HALF_W-1:0] REDUCE_TOP = 64'hE100_0000_0000_0000;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LEN   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b1;

  // multiply by x in reflected bit order: right shift, fold the dropped bit back
  function automatic logic [BLOCK_W-1:0] times_x(input logic [BLOCK_W-1:0] w);
    logic [BLOCK_W-1:0] r;
    r = w >> 1;
    if (w[0]) begin
      r[BLOCK_W-1:HALF_W] = r[BLOCK_W-1:HALF_W] ^ REDUCE_TOP;
    end
    return r;
  endfunction

  // multiply by x^n, n at most MAX_DIGIT_BITS
  function automatic logic [BLOCK_W-1:0] times_x_n(input logic [BLOCK_W-1:0] w,
                                                   input int n);
    logic [BLOCK_W-1:0] r;
    r = w;
    for (int j = 0; j < MAX_DIGIT_BITS; j++) begin
      if (j < n) begin
        r = times_x(r);
      end
    end
    return r;
  endfunction

endpackage

// File: design/ghash_table_ram.sv
// ghash_table_ram: single-port-write, single-port-read synchronous memory
// holding the key multiple table; read data is registered.
// Depends on nothing.
module ghash_table_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 128
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ghash_entry_gen.sv
// ghash_entry_gen: forms one key table entry, H times the reflected digit idx,
// as a sum of H, H*x, ... chosen by the digit bits.
// Depends on ghash_pkg.
module ghash_entry_gen
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic [BLOCK_W-1:0]    key,
  input  logic [DIGIT_BITS-1:0] idx,
  output logic [BLOCK_W-1:0]    entry
);

  always_comb begin
    logic [BLOCK_W-1:0] p;
    logic [BLOCK_W-1:0] e;
    p = key;
    e = '0;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (idx[DIGIT_BITS-1-j]) begin
        e = e ^ p;
      end
      p = times_x(p);
    end
    entry = e;
  end

endmodule

// File: design/ghash_gf128_accumulator.sv
// GHASH accumulator for GCM. An absorb request (data or length block) computes
// acc = (acc xor block) * H with a digit-serial Horner multiply that reads one
// key-table entry per digit from a synchronous memory; s_tready stays low until
// the result has moved to the output register. Clear and unused commands skip
// the multiply. After reset and after every key register write the table is
// rebuilt, one entry a cycle, all 2**DIGIT_BITS entries, during which s_tready
// stays low. A result waits in the output register.
// Depends on ghash_pkg, ghash_table_ram and ghash_entry_gen.
module ghash_gf128_accumulator
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // block_high [63:0], block_low [127:64], valid_bytes [132:128], zero fill
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // cmd [1:0]
  input  logic [CMD_W-1:0]       s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // acc_high [63:0], acc_low [127:64]
  output logic [M_TDATA_W-1:0]   m_tdata,
  output logic                   m_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIGIT_COUNT = (BLOCK_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int TOT_W       = DIGIT_COUNT * DIGIT_BITS;
  localparam int PAD_W       = TOT_W - BLOCK_W;
  localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
  localparam logic [DIGIT_BITS-1:0] ENTRY_LAST = DIGIT_BITS'((1 << DIGIT_BITS) - 1);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state;
  logic [DIGIT_BITS-1:0] sweep;
  logic [HALF_W-1:0]     key_high;
  logic [HALF_W-1:0]     key_low;
  logic [BLOCK_W-1:0]    acc;
  logic [BLOCK_W-1:0]    v;
  logic [TOT_W-1:0]      opnd;
  logic [CNT_W-1:0]      cnt;
  logic                  rvalid;
  logic                  fin;
  logic [BLOCK_W-1:0]    entry;
  logic [BLOCK_W-1:0]    rdata;
  logic [BLOCK_W-1:0]    blk;
  logic [BLOCK_W-1:0]    mask;
  logic [VBYTES_W-1:0]   valid_bytes;
  logic                  out_load;

  ghash_entry_gen #(
    .DIGIT_BITS(DIGIT_BITS)
  ) u_entry (
    .key   ({key_high, key_low}),
    .idx   (sweep),
    .entry (entry)
  );

  ghash_table_ram #(
    .ADDR_W(DIGIT_BITS),
    .DATA_W(BLOCK_W)
  ) u_table (
    .clk   (clk),
    .we    (state == ST_INIT),
    .waddr (sweep),
    .wdata (entry),
    .raddr (opnd[DIGIT_BITS-1:0]),
    .rdata (rdata)
  );

  assign s_tready    = (state == ST_IDLE);
  assign valid_bytes = s_tdata[2*HALF_W +: VBYTES_W];
  assign blk         = {s_tdata[HALF_W-1:0], s_tdata[2*HALF_W-1:HALF_W]};
  assign out_load    = (state == ST_DONE) && !cfg_we && (!m_tvalid || m_tready);

  // byte 0 sits in the top bits; length blocks keep all bytes
  always_comb begin
    mask = '0;
    for (int k = 0; k < BLOCK_W / 8; k++) begin
      if (s_tuser == CMD_LEN || valid_bytes > VBYTES_W'(k)) begin
        mask[BLOCK_W-1-8*k -: 8] = 8'hFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      sweep    <= '0;
      rvalid   <= 1'b0;
      m_tvalid <= 1'b0;
      acc      <= '0;
      key_high <= '0;
      key_low  <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // key change restarts the table rebuild
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: begin
            key_high <= cfg_data;
            state    <= ST_INIT;
            sweep    <= '0;
          end
          REG_KEY_LOW: begin
            key_low <= cfg_data;
            state   <= ST_INIT;
            sweep   <= '0;
          end
          default: begin
          end
        endcase
      end else begin
        case (state)
          ST_INIT: begin
            if (sweep == ENTRY_LAST) begin
              state <= ST_IDLE;
            end
            sweep <= sweep + DIGIT_BITS'(1);
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              case (s_tuser)
                CMD_CLEAR: begin
                  v     <= '0;
                  fin   <= 1'b0;
                  state <= ST_DONE;
                end
                CMD_DATA, CMD_LEN: begin
                  opnd  <= TOT_W'(acc ^ (blk & mask)) << PAD_W;
                  cnt   <= CNT_W'(DIGIT_COUNT);
                  v     <= '0;
                  fin   <= (s_tuser == CMD_LEN);
                  state <= ST_MUL;
                end
                default: begin
                  v     <= acc;
                  fin   <= 1'b0;
                  state <= ST_DONE;
                end
              endcase
            end
          end
          ST_MUL: begin
            if (cnt != '0) begin
              cnt  <= cnt - CNT_W'(1);
              opnd <= opnd >> DIGIT_BITS;
            end
            rvalid <= (cnt != '0);
            if (rvalid) begin
              v <= times_x_n(v, DIGIT_BITS) ^ rdata;
            end
            if (cnt == '0 && !rvalid) begin
              state <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (out_load) begin
              m_tdata <= {v[HALF_W-1:0], v[BLOCK_W-1:HALF_W]};
              m_tlast <= fin;
              acc     <= v;
              state   <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_INIT;
          end
        endcase
      end
    end
  end

  a_rvalid_in_mul: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> (state == ST_MUL))
    else $error("table read pending outside multiply");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_CLEAR && !cfg_we)
      |=> (state == ST_DONE && v == '0 && !fin))
    else $error("clear request did not zero the result");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result issued outside completion state");

endmodule
